/* hw/rtl/cpit_pkg.sv */
// Shared constants, codes and types of the circular profile interpolation table.
`default_nettype none
package cpit_pkg;

    localparam int MAX_SAMPLES  = 1024;
    localparam int SECTOR_COUNT = 32;

    localparam int ADDR_W    = $clog2(MAX_SAMPLES);
    localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int SEC_SHIFT = $clog2(SECTOR_COUNT);

    localparam int LEN_W     = 16;
    localparam int ALT_IN_W  = 16;
    localparam int AZ_W      = 16;
    localparam int SEC_W     = 5;
    localparam int ALT_W     = 15;
    localparam int STAT_W    = 2;
    localparam int ACT_W     = 2;
    localparam int OUT_CNT_W = 11;

    localparam int MUL_W  = 18;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [ALT_W-1:0] ALT_FULL  = 15'd23040;
    localparam logic [LEN_W-1:0] LEN_RESET = 16'd1024;
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_SAMPLES);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_SAMPLES);

    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_INTERP = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SECTOR = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] quot;
        logic [CNT_W-1:0] rem;
    } t_div_out;

endpackage
`default_nettype wire

/* hw/rtl/cpit_if.sv */
// Request and result channel interfaces of the circular profile interpolation table.
`default_nettype none
interface cpit_in_if;
    import cpit_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [ALT_IN_W-1:0] altitude_in;
    logic [AZ_W-1:0]     azimuth;
    logic [SEC_W-1:0]    sector;

    modport source (output valid, action, altitude_in, azimuth, sector, input ready);
    modport sink   (input valid, action, altitude_in, azimuth, sector, output ready);
endinterface

interface cpit_out_if;
    import cpit_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STAT_W-1:0]    status;
    logic [ALT_W-1:0]     altitude_out;
    logic [ALT_W-1:0]     sector_max;
    logic [ALT_W-1:0]     sector_min;
    logic                 obstructed;
    logic [OUT_CNT_W-1:0] sample_count;

    modport source (output valid, status, altitude_out, sector_max, sector_min, obstructed,
                    sample_count, input ready);
    modport sink   (input valid, status, altitude_out, sector_max, sector_min, obstructed,
                    sample_count, output ready);
endinterface
`default_nettype wire

/* hw/rtl/cpit_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module cpit_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hw/rtl/cpit_div.sv */
// Iterative restoring divider, one quotient bit per cycle, for the sample step.
`default_nettype none
module cpit_div (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [cpit_pkg::LEN_W-1:0] i_dividend,
    input  wire logic [cpit_pkg::CNT_W-1:0] i_divisor,
    output      cpit_pkg::t_div_out     o_res
);
    import cpit_pkg::*;

    localparam int STEP_W = $clog2(LEN_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LEN_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [LEN_W-1:0]  r_quot;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvs;
    logic [CNT_W:0]    w_trial;
    logic              w_ge;
    logic [CNT_W-1:0]  w_rem_next;

    assign w_trial    = {r_rem, r_quot[LEN_W-1]};
    assign w_ge       = w_trial >= {1'b0, r_dvs};
    assign w_rem_next = w_ge ? CNT_W'(w_trial - {1'b0, r_dvs}) : CNT_W'(w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == LAST_STEP);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[LEN_W-2:0], w_ge};
            r_rem  <= w_rem_next;
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem;
endmodule
`default_nettype wire

/* hw/rtl/cpit_mul.sv */
// Shared signed multiplier with a registered product.
`default_nettype none
module cpit_mul (
    input  wire logic                                i_clk,
    input  wire logic signed [cpit_pkg::MUL_W-1:0]  i_a,
    input  wire logic signed [cpit_pkg::MUL_W-1:0]  i_b,
    output      logic signed [cpit_pkg::PROD_W-1:0] o_p
);
    import cpit_pkg::*;

    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end
endmodule
`default_nettype wire

/* hw/rtl/circular_profile_interp_table_core.sv */
// Top level of the circular profile interpolation table with its sequencer.
// Usage: requests enter on i_in as valid/ready beats carrying action, altitude_in,
// azimuth and sector; every request gives exactly one result beat on o_out.
// i_cfg_we with i_cfg_wdata sets the source length; write it while the block is idle.
// The block works on one request at a time and drops ready until its result is
// placed in the output register. Work between accept and result valid:
//   load sample, clear with zero length, or any empty-table query: straight to the result
//   clear with nonzero length: waits for the 16-step divider
//   interpolation query: two reads of the one RAM read port and two passes
//   through the shared multiplier
//   sector query: hi - lo + 1 table entries, one table entry read
//   per cycle through the RAM read port
// A new request can be taken in the cycle after the previous result is registered.
// When the receiver stalls, the result waits in the output register and the
// next request may be accepted and worked on; its result waits until the
// register is free. Synchronous reset clears the counters, sets the step to one
// and the source length to 1024; table contents are not cleared.
`default_nettype none
module circular_profile_interp_table_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [cpit_pkg::LEN_W-1:0]   i_cfg_wdata,
    cpit_in_if.sink                           i_in,
    cpit_out_if.source                        o_out
);
    import cpit_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_IMUL  = 4'd2;
    localparam logic [3:0] S_IRD0  = 4'd3;
    localparam logic [3:0] S_IRD1  = 4'd4;
    localparam logic [3:0] S_IMUL2 = 4'd5;
    localparam logic [3:0] S_IFIN  = 4'd6;
    localparam logic [3:0] S_SMUL0 = 4'd7;
    localparam logic [3:0] S_SMUL1 = 4'd8;
    localparam logic [3:0] S_SBND  = 4'd9;
    localparam logic [3:0] S_SCAN  = 4'd10;
    localparam logic [3:0] S_SFOLD = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0]         r_state;
    logic [LEN_W-1:0]   r_len;
    logic [CNT_W-1:0]   r_kept;
    logic [LEN_W-1:0]   r_pos;
    logic [LEN_W-1:0]   r_next;
    logic [CNT_W-1:0]   r_acc;
    logic [LEN_W-1:0]   r_quot;
    logic [CNT_W-1:0]   r_rem;
    logic               r_fold;
    logic               r_o_valid;

    logic [ACT_W-1:0]   r_act;
    logic [AZ_W-1:0]    r_az;
    logic [SEC_W-1:0]   r_sec;
    logic [STAT_W-1:0]  r_status;
    logic [ALT_W-1:0]   r_alt;
    logic [ALT_W-1:0]   r_max;
    logic [ALT_W-1:0]   r_min;
    logic [AZ_W-1:0]    r_f;
    logic [CNT_W-1:0]   r_i0;
    logic [ALT_W-1:0]   r_a0;
    logic [CNT_W-1:0]   r_i;
    logic [CNT_W-1:0]   r_hi;

    logic [STAT_W-1:0]    r_o_status;
    logic [ALT_W-1:0]     r_o_alt;
    logic [ALT_W-1:0]     r_o_max;
    logic [ALT_W-1:0]     r_o_min;
    logic                 r_o_obst;
    logic [OUT_CNT_W-1:0] r_o_cnt;

    logic                      w_accept;
    logic [CNT_W-1:0]          w_n;
    logic                      w_load_full;
    logic                      w_keep;
    logic [CNT_W:0]            w_acc_sum;
    logic                      w_acc_wrap;
    logic [LEN_W-1:0]          w_next_new;
    logic [ALT_W-1:0]          w_clamped;
    logic                      w_we;
    logic [ADDR_W-1:0]         w_raddr;
    logic [ALT_W-1:0]          w_rd;
    logic signed [MUL_W-1:0]   w_mul_a;
    logic signed [MUL_W-1:0]   w_mul_b;
    logic signed [PROD_W-1:0]  w_p;
    logic [CNT_W-1:0]          w_i1;
    logic signed [PROD_W:0]    w_sum;
    logic [PROD_W-1:0]         w_hi_sum;
    logic [MUL_W-1:0]          w_s;
    logic                      w_out_free;
    logic                      w_div_start;
    t_div_out                  w_div;

    assign w_accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_out_free = !r_o_valid || o_out.ready;

    assign w_n         = (r_len > LEN_MAX) ? CNT_MAX : CNT_W'(r_len);
    assign w_load_full = (r_kept >= w_n) || (r_pos >= r_len);
    assign w_keep      = (r_pos == r_next);
    assign w_acc_sum   = {1'b0, r_acc} + {1'b0, r_rem};
    assign w_acc_wrap  = w_acc_sum >= {1'b0, w_n};
    assign w_next_new  = r_next + r_quot + {{(LEN_W-1){1'b0}}, w_acc_wrap};

    always_comb begin
        if (i_in.altitude_in[ALT_IN_W-1]) begin
            w_clamped = '0;
        end else if (i_in.altitude_in > {1'b0, ALT_FULL}) begin
            w_clamped = ALT_FULL;
        end else begin
            w_clamped = i_in.altitude_in[ALT_W-1:0];
        end
    end

    assign w_we = w_accept && (i_in.action == ACT_LOAD) && !w_load_full && w_keep;
    assign w_div_start = w_accept && (i_in.action == ACT_CLEAR) && (w_n != '0);

    assign w_i1 = (r_i0 + 1'b1 == r_kept) ? '0 : r_i0 + 1'b1;
    assign w_s  = MUL_W'(r_sec % SECTOR_COUNT);

    always_comb begin
        case (r_state)
            S_IRD0:  w_raddr = w_p[AZ_W +: ADDR_W];
            S_IRD1:  w_raddr = w_i1[ADDR_W-1:0];
            S_SCAN:  w_raddr = (r_i == r_kept) ? '0 : r_i[ADDR_W-1:0];
            default: w_raddr = '0;
        endcase
    end

    always_comb begin
        case (r_state)
            S_IMUL: begin
                w_mul_a = MUL_W'(r_az);
                w_mul_b = MUL_W'(r_kept);
            end
            S_IMUL2: begin
                w_mul_a = MUL_W'(w_rd) - MUL_W'(r_a0);
                w_mul_b = MUL_W'(r_f);
            end
            S_SMUL0: begin
                w_mul_a = w_s;
                w_mul_b = MUL_W'(r_kept);
            end
            S_SMUL1: begin
                w_mul_a = w_s + 1'b1;
                w_mul_b = MUL_W'(r_kept);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_sum    = $signed({{(PROD_W-ALT_W-AZ_W+1){1'b0}}, r_a0, {AZ_W{1'b0}}})
                    + {w_p[PROD_W-1], w_p}
                    + $signed((PROD_W+1)'(32768));
    assign w_hi_sum = w_p + PROD_W'(SECTOR_COUNT - 1);

    cpit_ram #(
        .WIDTH(ALT_W),
        .DEPTH(MAX_SAMPLES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_kept[ADDR_W-1:0]),
        .i_wdata (w_clamped),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    cpit_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_p)
    );

    cpit_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_len),
        .i_divisor  (w_n),
        .o_res      (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= LEN_RESET;
            r_kept    <= '0;
            r_pos     <= '0;
            r_next    <= '0;
            r_acc     <= '0;
            r_quot    <= LEN_W'(1);
            r_rem     <= '0;
            r_fold    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            r_fold <= (r_state == S_SCAN);
            if (r_state == S_DONE && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_in.action)
                            ACT_CLEAR: begin
                                r_kept <= '0;
                                r_pos  <= '0;
                                r_next <= '0;
                                r_acc  <= '0;
                                if (w_n == '0) begin
                                    r_quot  <= LEN_W'(1);
                                    r_rem   <= '0;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                            ACT_LOAD: begin
                                if (!w_load_full) begin
                                    r_pos <= r_pos + 1'b1;
                                    if (w_keep) begin
                                        r_kept <= r_kept + 1'b1;
                                        r_next <= w_next_new;
                                        r_acc  <= w_acc_wrap ? CNT_W'(w_acc_sum - {1'b0, w_n})
                                                             : CNT_W'(w_acc_sum);
                                    end
                                end
                                r_state <= S_DONE;
                            end
                            ACT_INTERP: begin
                                r_state <= (r_kept == '0) ? S_DONE : S_IMUL;
                            end
                            default: begin
                                r_state <= (r_kept == '0) ? S_DONE : S_SMUL0;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_quot  <= w_div.quot;
                        r_rem   <= w_div.rem;
                        r_state <= S_DONE;
                    end
                end
                S_IMUL:  r_state <= S_IRD0;
                S_IRD0:  r_state <= S_IRD1;
                S_IRD1:  r_state <= S_IMUL2;
                S_IMUL2: r_state <= S_IFIN;
                S_IFIN:  r_state <= S_DONE;
                S_SMUL0: r_state <= S_SMUL1;
                S_SMUL1: r_state <= S_SBND;
                S_SBND:  r_state <= S_SCAN;
                S_SCAN: begin
                    if (r_i == r_hi) begin
                        r_state <= S_SFOLD;
                    end
                end
                S_SFOLD: r_state <= S_DONE;
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act <= i_in.action;
            r_az  <= i_in.azimuth;
            r_sec <= i_in.sector;
            r_alt <= '0;
            r_max <= '0;
            r_min <= '0;
            if (i_in.action == ACT_LOAD) begin
                r_status <= (w_load_full || !w_keep) ? ST_IGNORED : ST_OK;
            end else if (i_in.action != ACT_CLEAR && r_kept == '0) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_OK;
            end
        end
        if (r_state == S_IRD0) begin
            r_i0 <= w_p[AZ_W +: CNT_W];
            r_f  <= w_p[AZ_W-1:0];
        end
        if (r_state == S_IRD1) begin
            r_a0 <= w_rd;
        end
        if (r_state == S_IFIN) begin
            r_alt <= w_sum[AZ_W +: ALT_W];
        end
        if (r_state == S_SMUL1) begin
            r_i <= w_p[SEC_SHIFT +: CNT_W];
        end
        if (r_state == S_SBND) begin
            r_hi  <= w_hi_sum[SEC_SHIFT +: CNT_W];
            r_max <= '0;
            r_min <= ALT_FULL;
        end
        if (r_state == S_SCAN && r_i != r_hi) begin
            r_i <= r_i + 1'b1;
        end
        if (r_fold) begin
            if (w_rd > r_max) begin
                r_max <= w_rd;
            end
            if (w_rd < r_min) begin
                r_min <= w_rd;
            end
        end
        if (r_state == S_DONE && w_out_free) begin
            r_o_status <= r_status;
            r_o_alt    <= (r_act == ACT_INTERP) ? r_alt : '0;
            r_o_max    <= r_max;
            r_o_min    <= r_min;
            r_o_obst   <= (r_max != '0);
            r_o_cnt    <= OUT_CNT_W'(r_kept);
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.status       = r_o_status;
    assign o_out.altitude_out = r_o_alt;
    assign o_out.sector_max   = r_o_max;
    assign o_out.sector_min   = r_o_min;
    assign o_out.obstructed   = r_o_obst;
    assign o_out.sample_count = r_o_cnt;
endmodule
`default_nettype wire

/* bench/circular_profile_interp_table_core_tb.sv */
// Self-checking testbench: random profile loads and queries checked against a built-in predictor.
module circular_profile_interp_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cpit_pkg::*;

    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [ALT_IN_W-1:0] altitude_in;
        logic [AZ_W-1:0]     azimuth;
        logic [SEC_W-1:0]    sector;
    } profile_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [ALT_W-1:0]     altitude_out;
        logic [ALT_W-1:0]     sector_max;
        logic [ALT_W-1:0]     sector_min;
        logic                 obstructed;
        logic [OUT_CNT_W-1:0] sample_count;
    } profile_answer_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [LEN_W-1:0] i_cfg_wdata = '0;

    cpit_in_if  req_bus ();
    cpit_out_if res_bus ();

    circular_profile_interp_table_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (req_bus),
        .o_out       (res_bus)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state, a copy of the block's registers and table.
    logic [LEN_W-1:0] src_len;
    logic [ALT_W-1:0] alt_store [MAX_SAMPLES];
    logic [CNT_W-1:0] kept_cnt;
    logic [LEN_W-1:0] src_pos;
    logic [LEN_W-1:0] next_pos;
    logic [CNT_W-1:0] rem_acc;
    logic [LEN_W-1:0] step_quot;
    logic [CNT_W-1:0] step_rem;

    profile_req_t    requests_pending [$];
    profile_answer_t answers_due [$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int results_checked = 0;
    int kept_loads = 0;
    int deepest_table = 0;
    int beats_by_action [4] = '{0, 0, 0, 0};
    logic req_taken = 1'b0;
    logic drained = 1'b0;

    function automatic profile_answer_t predict_profile(profile_req_t rq);
        profile_answer_t ans;
        int unsigned n, cnt, p, i0, i1, frac, lo, hi;
        longint unsigned acc;
        logic signed [ALT_IN_W-1:0] raw;
        ans = '0;
        n = (src_len > MAX_SAMPLES) ? MAX_SAMPLES : src_len;
        raw = rq.altitude_in;
        cnt = kept_cnt;
        case (rq.action)
            ACT_CLEAR: begin
                kept_cnt = '0;
                src_pos = '0;
                next_pos = '0;
                rem_acc = '0;
                if (n == 0) begin
                    step_quot = 16'd1;
                    step_rem = '0;
                end else begin
                    step_quot = LEN_W'(src_len / n);
                    step_rem = CNT_W'(src_len % n);
                end
            end
            ACT_LOAD: begin
                if (kept_cnt >= n || src_pos >= src_len) begin
                    ans.status = ST_IGNORED;
                end else begin
                    if (src_pos == next_pos) begin
                        if (raw < 0)
                            alt_store[kept_cnt] = '0;
                        else if (int'(raw) > int'(ALT_FULL))
                            alt_store[kept_cnt] = ALT_FULL;
                        else
                            alt_store[kept_cnt] = raw[ALT_W-1:0];
                        kept_cnt = kept_cnt + 1'b1;
                        kept_loads++;
                        next_pos = next_pos + step_quot;
                        rem_acc = rem_acc + step_rem;
                        if (rem_acc >= n) begin
                            rem_acc = CNT_W'(rem_acc - n);
                            next_pos = next_pos + 1'b1;
                        end
                    end else begin
                        ans.status = ST_IGNORED;
                    end
                    src_pos = src_pos + 1'b1;
                end
            end
            default: begin
                if (cnt == 0) begin
                    ans.status = ST_EMPTY;
                end else if (rq.action == ACT_INTERP) begin
                    p = rq.azimuth * cnt;
                    i0 = (p >> 16) % cnt;
                    i1 = (i0 + 1 == cnt) ? 0 : i0 + 1;
                    frac = p & 32'hFFFF;
                    acc = 64'(alt_store[i0]) * (65536 - frac) + 64'(alt_store[i1]) * frac
                        + 64'd32768;
                    ans.altitude_out = ALT_W'(acc >> 16);
                end else begin
                    lo = (rq.sector % SECTOR_COUNT) * cnt / SECTOR_COUNT;
                    hi = ((rq.sector % SECTOR_COUNT + 1) * cnt + SECTOR_COUNT - 1)
                         / SECTOR_COUNT;
                    ans.sector_min = ALT_FULL;
                    for (int unsigned i = lo; i <= hi; i++) begin
                        if (alt_store[i % cnt] > ans.sector_max)
                            ans.sector_max = alt_store[i % cnt];
                        if (alt_store[i % cnt] < ans.sector_min)
                            ans.sector_min = alt_store[i % cnt];
                    end
                    ans.obstructed = (ans.sector_max != 0);
                end
            end
        endcase
        ans.sample_count = kept_cnt;
        return ans;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        profile_answer_t due;
        profile_req_t rq;
        if (!i_rst_n) begin
            src_len = LEN_RESET;
            kept_cnt = '0;
            src_pos = '0;
            next_pos = '0;
            rem_acc = '0;
            step_quot = 16'd1;
            step_rem = '0;
        end else begin
            if (i_cfg_we)
                src_len = i_cfg_wdata;
            if (res_bus.valid && res_bus.ready) begin
                if (answers_due.size() == 0) begin
                    $error("result beat with no request outstanding");
                    mismatches++;
                end else begin
                    due = answers_due.pop_front();
                    results_checked++;
                    check_field("status", due.status, res_bus.status);
                    check_field("altitude_out", due.altitude_out, res_bus.altitude_out);
                    check_field("sector_max", due.sector_max, res_bus.sector_max);
                    check_field("sector_min", due.sector_min, res_bus.sector_min);
                    check_field("obstructed", due.obstructed, res_bus.obstructed);
                    check_field("sample_count", due.sample_count, res_bus.sample_count);
                end
            end
            if (req_bus.valid && req_bus.ready) begin
                rq.action = req_bus.action;
                rq.altitude_in = req_bus.altitude_in;
                rq.azimuth = req_bus.azimuth;
                rq.sector = req_bus.sector;
                answers_due.push_back(predict_profile(rq));
                beats_by_action[rq.action]++;
                if (kept_cnt > deepest_table)
                    deepest_table = kept_cnt;
            end
        end
        req_taken <= req_bus.valid && req_bus.ready;
        drained <= requests_pending.size() == 0 && !req_bus.valid && answers_due.size() == 0;
    end

    always @(negedge i_clk) begin : driver
        profile_req_t nxt;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else if (!req_bus.valid || req_taken) begin
            if (requests_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = requests_pending.pop_front();
                req_bus.valid <= 1'b1;
                req_bus.action <= nxt.action;
                req_bus.altitude_in <= nxt.altitude_in;
                req_bus.azimuth <= nxt.azimuth;
                req_bus.sector <= nxt.sector;
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
        res_bus.ready <= i_rst_n && ($urandom_range(99) >= stall_pct);
    end

    function automatic profile_req_t mk_req(logic [ACT_W-1:0] act, logic [ALT_IN_W-1:0] alt,
                                            logic [AZ_W-1:0] az, logic [SEC_W-1:0] sec);
        profile_req_t rq;
        rq.action = act;
        rq.altitude_in = alt;
        rq.azimuth = az;
        rq.sector = sec;
        return rq;
    endfunction

    function automatic profile_req_t random_req(logic [ACT_W-1:0] act);
        logic [ALT_IN_W-1:0] alt;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: alt = ALT_IN_W'($urandom_range(int'(ALT_FULL)));
            6: alt = ALT_IN_W'($urandom_range(32767, int'(ALT_FULL) + 1));
            7: alt = ALT_IN_W'(-$urandom_range(32768, 1));
            8: alt = $urandom_range(1) ? ALT_IN_W'(ALT_FULL) : '0;
            default: alt = ALT_IN_W'($urandom);
        endcase
        return mk_req(act, alt, AZ_W'($urandom), SEC_W'($urandom));
    endfunction

    // A clear, a run of loads with queries mixed in, then a burst of queries.
    function automatic void queue_session(int loads, int queries);
        requests_pending.push_back(random_req(ACT_CLEAR));
        repeat (loads) begin
            if ($urandom_range(99) < 12)
                requests_pending.push_back(random_req(ACT_W'($urandom_range(ACT_INTERP,
                                                                            ACT_SECTOR))));
            requests_pending.push_back(random_req(ACT_LOAD));
        end
        repeat (queries)
            requests_pending.push_back(random_req(ACT_W'($urandom_range(ACT_INTERP,
                                                                        ACT_SECTOR))));
    endfunction

    task automatic settle();
        do @(negedge i_clk); while (!drained);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [LEN_W-1:0] len, input int send_pct, input int hold_pct,
                             input int sessions, input int loads_lo, input int loads_hi,
                             input int queries, input int stale_loads);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= len;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        send_idle_pct = send_pct;
        stall_pct = hold_pct;
        repeat (stale_loads)
            requests_pending.push_back(random_req(ACT_LOAD));
        repeat (sessions)
            queue_session($urandom_range(loads_hi, loads_lo), queries);
    endtask

    initial begin
        req_bus.valid = 1'b0;
        req_bus.action = ACT_CLEAR;
        req_bus.altitude_in = '0;
        req_bus.azimuth = '0;
        req_bus.sector = '0;
        res_bus.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        requests_pending.push_back(mk_req(ACT_INTERP, 16'h0000, 16'h0000, 5'd0));
        requests_pending.push_back(mk_req(ACT_SECTOR, 16'h0000, 16'hFFFF, 5'd31));
        requests_pending.push_back(mk_req(ACT_LOAD, 16'd100, 16'h0000, 5'd0));
        requests_pending.push_back(mk_req(ACT_LOAD, 16'h8000, 16'h0000, 5'd0));
        requests_pending.push_back(mk_req(ACT_INTERP, 16'h0000, 16'hFFFF, 5'd0));
        requests_pending.push_back(mk_req(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 5'd31));
        requests_pending.push_back(mk_req(ACT_LOAD, 16'd12345, 16'h0000, 5'd0));
        requests_pending.push_back(mk_req(ACT_INTERP, 16'h0000, 16'hFFFF, 5'd0));
        requests_pending.push_back(mk_req(ACT_SECTOR, 16'h0000, 16'h0000, 5'd0));
        requests_pending.push_back(mk_req(ACT_LOAD, 16'h7FFF, 16'h0000, 5'd0));
        requests_pending.push_back(mk_req(ACT_LOAD, 16'd23041, 16'h0000, 5'd0));
        requests_pending.push_back(mk_req(ACT_LOAD, 16'hFFFF, 16'h0000, 5'd0));
        requests_pending.push_back(mk_req(ACT_LOAD, 16'h0000, 16'h0000, 5'd0));
        requests_pending.push_back(mk_req(ACT_LOAD, 16'd23040, 16'h0000, 5'd0));
        requests_pending.push_back(mk_req(ACT_INTERP, 16'h0000, 16'h0000, 5'd0));
        requests_pending.push_back(mk_req(ACT_INTERP, 16'h0000, 16'h8000, 5'd0));
        requests_pending.push_back(mk_req(ACT_INTERP, 16'h0000, 16'hFFFF, 5'd0));
        requests_pending.push_back(mk_req(ACT_SECTOR, 16'h0000, 16'h0000, 5'd31));
        requests_pending.push_back(mk_req(ACT_SECTOR, 16'h0000, 16'h0000, 5'd15));
        requests_pending.push_back(mk_req(ACT_SECTOR, 16'h0000, 16'h0000, 5'd0));

        run_phase(16'd1, 0, 0, 8, 1, 4, 3, 0);
        run_phase(16'd7, 55, 0, 6, 3, 10, 5, 2);
        run_phase(16'd2, 0, 55, 6, 1, 4, 5, 0);
        run_phase(16'd40, 30, 30, 2, 20, 45, 10, 0);
        run_phase(16'd1500, 0, 0, 2, 30, 50, 10, 0);
        run_phase(16'd65535, 55, 0, 1, 100, 130, 10, 0);
        run_phase(16'd0, 0, 55, 3, 2, 4, 3, 2);
        run_phase(16'd1024, 30, 30, 1, 520, 520, 30, 0);
        run_phase(16'd300, 0, 0, 1, 30, 80, 10, 3);
        settle();
        repeat (40) @(negedge i_clk);

        $display("Checked %0d results over %0d clears and %0d loads (%0d kept),",
                 results_checked, beats_by_action[ACT_CLEAR], beats_by_action[ACT_LOAD],
                 kept_loads);
        $display("%0d interpolations, %0d sector scans, lengths 0 to 65535, table up to %0d.",
                 beats_by_action[ACT_INTERP], beats_by_action[ACT_SECTOR], deepest_table);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #6ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
